// ===== rtl/prmt_pkg.sv =====
`default_nettype none
package prmt_pkg;

    localparam int LEAVES   = 1024;
    localparam int VERSIONS = 1024;
    localparam int NODES    = 16384;

    localparam int ACT_W = 1;
    localparam int POS_W = 10;
    localparam int VER_W = 10;
    localparam int VAL_W = 21;
    localparam int ST_W  = 2;

    localparam int NODE_W  = $clog2(NODES);
    localparam int NCNT_W  = $clog2(NODES + 1);
    localparam int VCNT_W  = $clog2(VERSIONS + 1);
    localparam int VADDR_W = $clog2(VERSIONS);
    localparam int LEVELS  = $clog2(LEAVES);
    localparam int LVL_W   = $clog2(LEVELS + 1);
    localparam int LVL_IW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [VAL_W-1:0] EMPTY_VAL = VAL_W'(1048576);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(LEAVES - 1);

    localparam logic [ACT_W-1:0] ACT_QUERY  = 1'b0;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 1'b1;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_VER   = 2'd1;
    localparam logic [ST_W-1:0] ST_POOL_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_VER_FULL  = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [VER_W-1:0] version;
        logic [POS_W-1:0] range_low;
        logic [POS_W-1:0] range_high;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [VAL_W-1:0] min_value;
        logic [VER_W-1:0] new_version;
        logic [ST_W-1:0]  status;
    } out_t;

    typedef struct packed {
        logic [NODE_W-1:0] lc;
        logic [NODE_W-1:0] rc;
        logic [VAL_W-1:0]  val;
    } node_t;

    typedef struct packed {
        logic [NODE_W-1:0] nd;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
    } frame_t;

endpackage
`default_nettype wire

// ===== rtl/prmt_ram.sv =====
`default_nettype none
module prmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/persistent_range_min_tree.sv =====
`default_nettype none
// Versioned range-minimum tree. Issue an item with start while busy is low; busy stays
// high until the result appears for one cycle with done, and the receiver cannot stall it.
// Tree nodes sit in a node RAM with one read port, version roots in a root RAM; the
// rate is set by node reads, one every cycle at most. A query visits roughly 4 nodes
// per level over 10 levels; an update walks the path reading each sibling, then makes
// levels + 1 node writes and one version write. Bad versions and a full version table
// are rejected in the root state, a full pool after the walk. No clearing pass is
// needed after reset: node 0 and version 0 are produced by logic.
module persistent_range_min_tree (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire prmt_pkg::in_t request,
    output logic               done,
    output prmt_pkg::out_t     result
);
    import prmt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ROOT, S_Q_VISIT, S_Q_WAIT, S_Q_POP,
        S_U_PATH, S_U_SIB, S_U_CHK, S_U_BUILD, S_U_ROOTW
    } state_t;

    state_t             state_reg;
    in_t                req_reg;
    out_t               result_reg;
    logic               done_reg;
    logic [VCNT_W-1:0]  version_count_reg;
    logic [NCNT_W-1:0]  node_count_reg;
    logic               root_zero_reg;
    logic               node_zero_reg;
    frame_t             cur_reg;
    frame_t             stack_reg [LEVELS];
    logic [LVL_W-1:0]   sp_reg;
    logic [VAL_W-1:0]   acc_reg;
    logic [LVL_W-1:0]   depth_reg;
    logic               went_left_reg [LEVELS];
    logic [NODE_W-1:0]  sib_idx_reg [LEVELS];
    logic [VAL_W-1:0]   sib_val_reg [LEVELS];
    logic [NODE_W-1:0]  cur_idx_reg;
    logic [VAL_W-1:0]   cur_val_reg;

    logic [NODE_W-1:0]  root_q;
    logic [NODE_W-1:0]  root_raw;
    logic               root_we;
    node_t              node_raw;
    node_t              node_q;
    logic [NODE_W-1:0]  node_raddr;
    logic               node_we;
    node_t              node_wdata;

    logic [POS_W-1:0]   mid;
    logic [POS_W:0]     lohi_sum;
    logic               disjoint;
    logic               covered;
    logic               go_left;
    logic [POS_W-1:0]   pos_clamped;
    logic [VAL_W-1:0]   val_clamped;
    logic [LVL_IW-1:0]  top_idx;
    logic [LVL_IW-1:0]  sp_idx;
    logic [LVL_IW-1:0]  dep_idx;
    logic [LVL_IW-1:0]  dep_m1_idx;
    logic [LVL_W-1:0]   depth_m1;
    logic [LVL_W-1:0]   sp_m1;
    logic [NCNT_W-1:0]  free_nodes;
    logic [VAL_W-1:0]   par_val;
    logic               bad_ver;

    prmt_ram #(.WIDTH(NODE_W), .DEPTH(VERSIONS)) u_roots (
        .clk   (clk),
        .we    (root_we),
        .waddr (version_count_reg[VADDR_W-1:0]),
        .wdata (cur_idx_reg),
        .raddr (request.version[VADDR_W-1:0]),
        .rdata (root_raw)
    );

    prmt_ram #(.WIDTH($bits(node_t)), .DEPTH(NODES)) u_nodes (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_count_reg[NODE_W-1:0]),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_raw)
    );

    // Node 0 and version 0 are never written; their contents come from logic.
    assign root_q = root_zero_reg ? '0 : root_raw;
    assign node_q = node_zero_reg ? node_t'{lc: '0, rc: '0, val: EMPTY_VAL} : node_raw;

    assign lohi_sum    = {1'b0, cur_reg.lo} + {1'b0, cur_reg.hi};
    assign mid         = lohi_sum[POS_W:1];
    assign disjoint    = (cur_reg.lo > req_reg.range_high) || (cur_reg.hi < req_reg.range_low);
    assign covered     = (req_reg.range_low <= cur_reg.lo) && (cur_reg.hi <= req_reg.range_high);
    assign pos_clamped = (req_reg.position > LAST_POS) ? LAST_POS : req_reg.position;
    assign val_clamped = (req_reg.value > EMPTY_VAL) ? EMPTY_VAL : req_reg.value;
    assign go_left     = pos_clamped <= mid;
    assign sp_m1       = sp_reg - LVL_W'(1);
    assign depth_m1    = depth_reg - LVL_W'(1);
    assign top_idx     = sp_m1[LVL_IW-1:0];
    assign sp_idx      = sp_reg[LVL_IW-1:0];
    assign dep_idx     = depth_reg[LVL_IW-1:0];
    assign dep_m1_idx  = depth_m1[LVL_IW-1:0];
    assign free_nodes  = NCNT_W'(NODES) - node_count_reg;
    assign par_val     = (cur_val_reg < sib_val_reg[dep_m1_idx]) ? cur_val_reg
                                                                 : sib_val_reg[dep_m1_idx];
    assign bad_ver     = {{(VCNT_W-VER_W){1'b0}}, req_reg.version} >= version_count_reg;

    always_comb
    begin
        node_raddr = '0;
        node_we    = 1'b0;
        node_wdata = node_t'{lc: '0, rc: '0, val: val_clamped};
        root_we    = 1'b0;
        case (state_reg)
            S_ROOT:
            begin
                node_raddr = root_q;
            end
            S_Q_VISIT:
            begin
                node_raddr = cur_reg.nd;
            end
            S_U_PATH:
            begin
                node_raddr = go_left ? node_q.rc : node_q.lc;
            end
            S_U_SIB:
            begin
                node_raddr = cur_reg.nd;
            end
            S_U_CHK:
            begin
                node_we = free_nodes >= NCNT_W'(depth_reg) + NCNT_W'(1);
            end
            S_U_BUILD:
            begin
                node_we    = 1'b1;
                node_wdata = went_left_reg[dep_m1_idx]
                    ? node_t'{lc: cur_idx_reg, rc: sib_idx_reg[dep_m1_idx], val: par_val}
                    : node_t'{lc: sib_idx_reg[dep_m1_idx], rc: cur_idx_reg, val: par_val};
            end
            S_U_ROOTW:
            begin
                root_we = 1'b1;
            end
            default:
            begin
                node_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        node_zero_reg <= (node_raddr == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            done_reg          <= 1'b0;
            version_count_reg <= VCNT_W'(1);
            node_count_reg    <= NCNT_W'(1);
            sp_reg            <= '0;
            depth_reg         <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg       <= request;
                        root_zero_reg <= (request.version == '0);
                        state_reg     <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    cur_reg   <= frame_t'{nd: root_q, lo: '0, hi: LAST_POS};
                    sp_reg    <= '0;
                    depth_reg <= '0;
                    acc_reg   <= EMPTY_VAL;
                    if (bad_ver)
                    begin
                        result_reg <= out_t'{
                            min_value: (req_reg.action == ACT_QUERY) ? EMPTY_VAL : '0,
                            new_version: '0, status: ST_BAD_VER};
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else if (req_reg.action == ACT_QUERY)
                    begin
                        state_reg <= S_Q_VISIT;
                    end
                    else if (version_count_reg >= VCNT_W'(VERSIONS))
                    begin
                        result_reg <= out_t'{min_value: '0, new_version: '0,
                                             status: ST_VER_FULL};
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_U_PATH;
                    end
                end
                S_Q_VISIT:
                begin
                    state_reg <= disjoint ? S_Q_POP : S_Q_WAIT;
                end
                S_Q_WAIT:
                begin
                    if (covered || (cur_reg.lo >= cur_reg.hi))
                    begin
                        if (node_q.val < acc_reg)
                        begin
                            acc_reg <= node_q.val;
                        end
                        state_reg <= S_Q_POP;
                    end
                    else
                    begin
                        stack_reg[sp_idx] <= frame_t'{nd: node_q.rc,
                                                      lo: mid + POS_W'(1), hi: cur_reg.hi};
                        sp_reg    <= sp_reg + LVL_W'(1);
                        cur_reg   <= frame_t'{nd: node_q.lc, lo: cur_reg.lo, hi: mid};
                        state_reg <= S_Q_VISIT;
                    end
                end
                S_Q_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        result_reg <= out_t'{min_value: acc_reg, new_version: '0,
                                             status: ST_OK};
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        cur_reg   <= stack_reg[top_idx];
                        sp_reg    <= sp_m1;
                        state_reg <= S_Q_VISIT;
                    end
                end
                S_U_PATH:
                begin
                    went_left_reg[dep_idx] <= go_left;
                    sib_idx_reg[dep_idx]   <= go_left ? node_q.rc : node_q.lc;
                    if (go_left)
                    begin
                        cur_reg <= frame_t'{nd: node_q.lc, lo: cur_reg.lo, hi: mid};
                    end
                    else
                    begin
                        cur_reg <= frame_t'{nd: node_q.rc, lo: mid + POS_W'(1),
                                            hi: cur_reg.hi};
                    end
                    state_reg <= S_U_SIB;
                end
                S_U_SIB:
                begin
                    sib_val_reg[dep_idx] <= node_q.val;
                    depth_reg            <= depth_reg + LVL_W'(1);
                    state_reg            <= (cur_reg.lo < cur_reg.hi) ? S_U_PATH : S_U_CHK;
                end
                S_U_CHK:
                begin
                    if (node_we)
                    begin
                        cur_idx_reg    <= node_count_reg[NODE_W-1:0];
                        cur_val_reg    <= val_clamped;
                        node_count_reg <= node_count_reg + NCNT_W'(1);
                        state_reg      <= (depth_reg == '0) ? S_U_ROOTW : S_U_BUILD;
                    end
                    else
                    begin
                        result_reg <= out_t'{min_value: '0, new_version: '0,
                                             status: ST_POOL_FULL};
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_U_BUILD:
                begin
                    cur_idx_reg    <= node_count_reg[NODE_W-1:0];
                    cur_val_reg    <= par_val;
                    node_count_reg <= node_count_reg + NCNT_W'(1);
                    depth_reg      <= depth_m1;
                    if (depth_m1 == '0)
                    begin
                        state_reg <= S_U_ROOTW;
                    end
                end
                S_U_ROOTW:
                begin
                    result_reg <= out_t'{min_value: '0,
                                         new_version: version_count_reg[VER_W-1:0],
                                         status: ST_OK};
                    done_reg          <= 1'b1;
                    version_count_reg <= version_count_reg + VCNT_W'(1);
                    state_reg         <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== rtl/prmt_checker.sv =====
`default_nettype none
module prmt_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire prmt_pkg::in_t  request,
    input wire logic           done,
    input wire prmt_pkg::out_t result
);
    import prmt_pkg::*;

    // An accepted item always raises busy in the cycle after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // The block leaves its busy period only by delivering a result.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("busy dropped without a result");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("two results in consecutive cycles");

    // Updates rejected for a full version table or pool report no version and no minimum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_VER_FULL || result.status == ST_POOL_FULL))
        |-> (result.new_version == '0 && result.min_value == '0))
        else $error("rejected update carries data");

endmodule

bind persistent_range_min_tree prmt_checker u_prmt_checker (.*);
`default_nettype wire

// ===== tb/sv/prmt_checker.sv =====
`timescale 1ns / 1ps
module prmt_scoreboard
    import prmt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire in_t  request,
    input  wire logic done,
    input  wire out_t result,
    output int        fail_count,
    output int        pending,
    output int        ok_queries,
    output int        ok_updates,
    output int        rejects
);

    // Shadow copy of the versioned tree.
    logic [NODE_W-1:0] shadow_lc [NODES];
    logic [NODE_W-1:0] shadow_rc [NODES];
    logic [VAL_W-1:0]  shadow_val[NODES];
    logic [NODE_W-1:0] shadow_root[VERSIONS];
    int                shadow_vcount;
    int                shadow_ncount;
    out_t              expected_results[$];

    function automatic logic [VAL_W-1:0] subtree_min(int nd, int lo, int hi, int ql, int qr);
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        int               mid;
        if (lo > qr || hi < ql)
            return EMPTY_VAL;
        if ((ql <= lo && hi <= qr) || lo >= hi)
            return shadow_val[nd];
        mid = (lo + hi) / 2;
        a = subtree_min(shadow_lc[nd], lo, mid, ql, qr);
        b = subtree_min(shadow_rc[nd], mid + 1, hi, ql, qr);
        return (a < b) ? a : b;
    endfunction

    function automatic out_t apply_item(in_t req);
        out_t              r;
        int                sib[32];
        bit                went_left[32];
        int                depth;
        int                lo;
        int                hi;
        int                mid;
        int                nd;
        int                pos;
        int                cur;
        int                par;
        int                l;
        int                rr;
        logic [VAL_W-1:0]  v;
        r = '0;
        if (req.action == ACT_QUERY) begin
            if (req.version >= shadow_vcount) begin
                r.min_value = EMPTY_VAL;
                r.status = ST_BAD_VER;
            end
            else
                r.min_value = subtree_min(shadow_root[req.version], 0, LEAVES - 1,
                    req.range_low, req.range_high);
        end
        else if (req.version >= shadow_vcount)
            r.status = ST_BAD_VER;
        else if (shadow_vcount >= VERSIONS)
            r.status = ST_VER_FULL;
        else begin
            depth = 0;
            lo = 0;
            hi = LEAVES - 1;
            nd = shadow_root[req.version];
            pos = (req.position > hi) ? hi : req.position;
            v = (req.value > EMPTY_VAL) ? EMPTY_VAL : req.value;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (pos <= mid) begin
                    went_left[depth] = 1'b1;
                    sib[depth] = shadow_rc[nd];
                    nd = shadow_lc[nd];
                    hi = mid;
                end
                else begin
                    went_left[depth] = 1'b0;
                    sib[depth] = shadow_lc[nd];
                    nd = shadow_rc[nd];
                    lo = mid + 1;
                end
                depth++;
            end
            if (NODES - shadow_ncount < depth + 1)
                r.status = ST_POOL_FULL;
            else begin
                cur = shadow_ncount++;
                shadow_lc[cur] = '0;
                shadow_rc[cur] = '0;
                shadow_val[cur] = v;
                while (depth > 0) begin
                    par = shadow_ncount++;
                    depth--;
                    l = went_left[depth] ? cur : sib[depth];
                    rr = went_left[depth] ? sib[depth] : cur;
                    shadow_lc[par] = l;
                    shadow_rc[par] = rr;
                    shadow_val[par] = (shadow_val[l] < shadow_val[rr]) ?
                        shadow_val[l] : shadow_val[rr];
                    cur = par;
                end
                shadow_root[shadow_vcount] = cur;
                r.new_version = VER_W'(shadow_vcount);
                shadow_vcount++;
            end
        end
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n) begin
        out_t want;
        if (!rst_n) begin
            shadow_lc[0] = '0;
            shadow_rc[0] = '0;
            shadow_val[0] = EMPTY_VAL;
            shadow_root[0] = '0;
            shadow_vcount = 1;
            shadow_ncount = 1;
            expected_results.delete();
            fail_count <= 0;
            ok_queries <= 0;
            ok_updates <= 0;
            rejects <= 0;
        end
        else begin
            // A result and the next item can share an edge, so check first.
            if (done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, result);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_results.pop_front();
                    if (result !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, result);
                        fail_count <= fail_count + 1;
                    end
                    if (want.status != ST_OK)
                        rejects <= rejects + 1;
                    else if (want.new_version != 0)
                        ok_updates <= ok_updates + 1;
                    else
                        ok_queries <= ok_queries + 1;
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_item(request));
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import prmt_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  request;
    logic done;
    out_t result;
    int   fail_count;
    int   pending;
    int   ok_queries;
    int   ok_updates;
    int   rejects;
    int   versions_made;

    persistent_range_min_tree u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .request(request), .done(done), .result(result)
    );

    prmt_scoreboard u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .fail_count(fail_count), .pending(pending),
        .ok_queries(ok_queries), .ok_updates(ok_updates), .rejects(rejects)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Start stays high across items sent without a gap, so that each
    // time step drives it at most once.
    task automatic send_item(in_t req, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        if (!no_gap && $urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            request <= in_t'($urandom());
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (req.action == ACT_UPDATE)
            versions_made++;
    endtask

    function automatic in_t make_item(bit act, int ver, int lo, int hi, int pos, int val);
        in_t r;
        r.action = act;
        r.version = ver;
        r.range_low = lo;
        r.range_high = hi;
        r.position = pos;
        r.value = val;
        return r;
    endfunction

    // Mostly valid versions, mostly in-range values, plus some noise.
    function automatic in_t random_item(bit burst);
        in_t r;
        int  top;
        int  a;
        int  b;
        r = in_t'({$urandom(), $urandom(), $urandom()});
        top = (versions_made >= VERSIONS) ? VERSIONS - 1 : versions_made;
        if ($urandom_range(0, 15) != 0)
            r.version = $urandom_range(0, top);
        r.action = ($urandom_range(0, 99) < (burst ? 70 : 45)) ? ACT_UPDATE : ACT_QUERY;
        if ($urandom_range(0, 7) != 0)
            r.value = $urandom_range(0, 1100000);
        if ($urandom_range(0, 3) != 0) begin
            a = $urandom_range(0, LEAVES - 1);
            b = $urandom_range(0, LEAVES - 1);
            r.range_low = (a < b) ? a : b;
            r.range_high = (a < b) ? b : a;
        end
        return r;
    endfunction

    initial
    begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        versions_made = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: empty tree, unknown version, extremes, sentinel and saturation.
        send_item(make_item(ACT_QUERY, 0, 0, LEAVES - 1, 0, 0), 1'b0);
        send_item(make_item(ACT_QUERY, 1, 0, 5, 0, 0), 1'b0);
        send_item(make_item(ACT_UPDATE, 5, 0, 0, 3, 7), 1'b0);
        send_item(make_item(ACT_UPDATE, 0, 0, 0, 0, 0), 1'b0);
        send_item(make_item(ACT_UPDATE, 1, 0, 0, 1023, 1048576), 1'b1);
        send_item(make_item(ACT_UPDATE, 2, 0, 0, 511, 2097151), 1'b0);
        send_item(make_item(ACT_UPDATE, 3, 0, 0, 512, 12345), 1'b1);
        send_item(make_item(ACT_UPDATE, 0, 0, 0, 700, 1), 1'b0);
        send_item(make_item(ACT_QUERY, 4, 0, 1023, 0, 0), 1'b0);
        send_item(make_item(ACT_QUERY, 4, 1, 1023, 0, 0), 1'b1);
        send_item(make_item(ACT_QUERY, 4, 511, 512, 0, 0), 1'b0);
        send_item(make_item(ACT_QUERY, 4, 600, 300, 0, 0), 1'b0);
        send_item(make_item(ACT_QUERY, 4, 1023, 1023, 0, 0), 1'b0);
        send_item(make_item(ACT_QUERY, 5, 0, 1023, 0, 0), 1'b0);
        send_item(make_item(ACT_QUERY, 1, 0, 0, 0, 0), 1'b0);
        send_item(make_item(ACT_QUERY, 1023, 0, 1023, 0, 0), 1'b0);
        send_item(make_item(ACT_UPDATE, 1023, 0, 0, 0, 0), 1'b0);
        // Random: long update bursts use up the version table.
        for (int i = 0; i < 1550; i++)
            send_item(random_item(i < 1200), $urandom_range(0, 4) == 0);
        start <= 1'b0;
        wait_cycles = 0;
        while ((pending != 0 || busy) && wait_cycles < 100000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);
        $display("Covered %0d good queries, %0d good updates, %0d rejected items.",
            ok_queries, ok_updates, rejects);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
